// ===== rtl/open_addressing_hash_table_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the open addressing hash table
// Shared concurrent-check wrappers with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH

// Same-cycle implication
`define OAHT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define OAHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// oaht_pkg
// Types and constants shared by the hash table controller and datapath.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int KEY_W     = 32;
    localparam int HASH_W    = 32;
    localparam int VALUE_W   = 64;
    localparam int COUNT_W   = 9;
    localparam int LIMIT_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int OP_W      = 2;
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 80;

    // Hash reduction for slot counts that are not a power of two
    localparam int MOD_CHUNK = 8;
    localparam int MOD_STEPS = HASH_W / MOD_CHUNK;

    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 8'd192;

    typedef enum logic [OP_W-1:0] {
        OP_SET   = 2'd0,
        OP_GET   = 2'd1,
        OP_DEL   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 3'd0,
        STAT_UPDATED  = 3'd1,
        STAT_FOUND    = 3'd2,
        STAT_MISSING  = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_DELETED  = 3'd5
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // latch the input transaction
        logic mod_step;    // advance the hash reduction
        logic probe_init;  // read the first slot of the probe
        logic probe_step;  // evaluate one slot, read the next
        logic sweep_step;  // clear one slot of the key store
        logic commit;      // update the table and load the result
    } oaht_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mod_done;
        logic is_clear;
        logic trivial;     // answer without probing
        logic probe_stop;
        logic sweep_last;
        logic out_free;
    } oaht_sts_t;

endpackage

// ===== rtl/oaht_ctrl.sv =====
// ----------------------------------------------------------------------------
// oaht_ctrl
// Sequencer for one table operation: hash reduction, probe, commit, sweep.
// ----------------------------------------------------------------------------
`include "open_addressing_hash_table_macros.svh"

module oaht_ctrl
    import oaht_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  oaht_sts_t sts,
    output oaht_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_HASH   = 7'b0000100,
        S_START  = 7'b0001000,
        S_PROBE  = 7'b0010000,
        S_WIPE   = 7'b0100000,
        S_COMMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: begin
                if (sts.sweep_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) state_next = S_HASH;
            end
            S_HASH: begin
                if (sts.is_clear)     state_next = S_WIPE;
                else if (sts.trivial) state_next = S_COMMIT;
                else if (sts.mod_done) state_next = S_START;
            end
            S_START: begin
                state_next = S_PROBE;
            end
            S_PROBE: begin
                if (sts.probe_stop) state_next = S_COMMIT;
            end
            S_WIPE: begin
                if (sts.sweep_last) state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Commands
    always_comb begin
        cmd            = '0;
        cmd.accept     = s_tvalid && (state_reg == S_IDLE);
        cmd.mod_step   = (state_reg == S_HASH);
        cmd.probe_init = (state_reg == S_START);
        cmd.probe_step = (state_reg == S_PROBE);
        cmd.sweep_step = (state_reg == S_INIT) || (state_reg == S_WIPE);
        cmd.commit     = (state_reg == S_COMMIT) && sts.out_free;
    end

    `OAHT_ASSERT_NEXT(a_accept_hash, aclk, aresetn, s_tvalid && s_tready, state_reg == S_HASH, "accepted transaction did not start hashing")
    `OAHT_ASSERT_NEXT(a_wipe_commit, aclk, aresetn, (state_reg == S_WIPE) && sts.sweep_last, state_reg == S_COMMIT, "clear sweep did not end in commit")
    `OAHT_ASSERT_NEXT(a_probe_hold, aclk, aresetn, (state_reg == S_PROBE) && !sts.probe_stop, state_reg == S_PROBE, "probe left before a stop")

endmodule

// ===== rtl/oaht_datapath.sv =====
// ----------------------------------------------------------------------------
// oaht_datapath
// Slot stores, hash reduction, probe walker, occupancy and result register.
// ----------------------------------------------------------------------------
`include "open_addressing_hash_table_macros.svh"

module oaht_datapath
    import oaht_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  oaht_cmd_t           cmd,
    output oaht_sts_t           sts,
    input  logic [OP_W-1:0]     in_op,
    input  logic [KEY_W-1:0]    in_key,
    input  logic [HASH_W-1:0]   in_hash,
    input  logic [VALUE_W-1:0]  in_value,
    input  logic                cfg_wr_en,
    input  logic [LIMIT_W-1:0]  cfg_wr_data,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [STATUS_W-1:0] out_status,
    output logic [VALUE_W-1:0]  out_read_value,
    output logic [COUNT_W-1:0]  out_occupancy
);

    localparam int IDX_W      = $clog2(SLOTS);
    localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Latched transaction
    op_t                op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg    <= op_t'(in_op);
            key_reg   <= in_key;
            value_reg <= in_value;
        end
    end

    // Load limit register
    logic [LIMIT_W-1:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LOAD_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Starting slot: hash modulo slot count
    logic [IDX_W-1:0] start_idx;
    logic             mod_done;

    if (SLOTS_POW2) begin : g_mod_mask
        logic [IDX_W-1:0] start_reg;

        always_ff @(posedge aclk) begin
            if (cmd.accept) start_reg <= in_hash[IDX_W-1:0];
        end

        assign start_idx = start_reg;
        assign mod_done  = 1'b1;
    end else begin : g_mod_serial
        localparam int CNT_W = $clog2(MOD_STEPS);

        logic [IDX_W-1:0]  mod_rem_reg, mod_rem_next;
        logic [HASH_W-1:0] mod_shift_reg;
        logic [CNT_W-1:0]  mod_cnt_reg;
        logic              mod_done_reg;
        logic              mod_go;

        assign mod_go = cmd.mod_step && !mod_done_reg;

        // Restoring reduction, one chunk of hash bits per cycle
        always_comb begin
            logic [IDX_W:0] r;
            r = {1'b0, mod_rem_reg};
            for (int i = 0; i < MOD_CHUNK; i++) begin
                r = {r[IDX_W-1:0], mod_shift_reg[HASH_W-1-i]};
                if (r >= (IDX_W+1)'(SLOTS)) r = r - (IDX_W+1)'(SLOTS);
            end
            mod_rem_next = r[IDX_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (cmd.accept) begin
                mod_rem_reg   <= '0;
                mod_shift_reg <= in_hash;
            end else if (mod_go) begin
                mod_rem_reg   <= mod_rem_next;
                mod_shift_reg <= mod_shift_reg << MOD_CHUNK;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mod_cnt_reg  <= '0;
                mod_done_reg <= 1'b0;
            end else if (cmd.accept) begin
                mod_cnt_reg  <= '0;
                mod_done_reg <= 1'b0;
            end else if (mod_go) begin
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == CNT_W'(MOD_STEPS - 1)) mod_done_reg <= 1'b1;
            end
        end

        assign start_idx = mod_rem_reg;
        assign mod_done  = mod_done_reg;
    end

    // Slot stores: key store holds {tombstone, key}
    logic [KEY_W:0]     key_mem [SLOTS];
    logic [VALUE_W-1:0] val_mem [SLOTS];
    logic [KEY_W:0]     key_rd_reg;
    logic [VALUE_W-1:0] val_rd_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               key_we, val_we;
    logic [IDX_W-1:0]   key_waddr;
    logic [KEY_W:0]     key_wdata;
    logic               commit_key_we;
    logic [KEY_W:0]     commit_key_wdata;
    logic [IDX_W-1:0]   where_reg;

    always_ff @(posedge aclk) begin
        if (key_we) key_mem[key_waddr] <= key_wdata;
        key_rd_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (val_we) val_mem[where_reg] <= value_reg;
        val_rd_reg <= val_mem[rd_addr];
    end

    // Sweep counter for the clearing pass
    logic [IDX_W-1:0] sweep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else if (cmd.sweep_step) begin
            sweep_reg <= (sweep_reg == LAST_IDX) ? '0 : sweep_reg + 1'b1;
        end
    end

    assign key_we    = cmd.sweep_step || (cmd.commit && commit_key_we);
    assign key_waddr = cmd.sweep_step ? sweep_reg : where_reg;
    assign key_wdata = cmd.sweep_step ? '0 : commit_key_wdata;

    // Probe walker
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   pcnt_reg;
    logic               have_tomb_reg;
    logic [IDX_W-1:0]   tomb_reg;
    logic               matched_reg, fresh_reg, ok_reg;
    logic [VALUE_W-1:0] hit_val_reg;
    logic               slot_empty, slot_tomb, slot_hit, probe_last, probe_stop;

    assign idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign rd_addr  = cmd.probe_init ? start_idx : idx_next;

    assign slot_empty = (key_rd_reg[KEY_W-1:0] == '0) && !key_rd_reg[KEY_W];
    assign slot_tomb  = (key_rd_reg[KEY_W-1:0] == '0) && key_rd_reg[KEY_W];
    assign slot_hit   = (key_rd_reg[KEY_W-1:0] != '0) && (key_rd_reg[KEY_W-1:0] == key_reg);
    assign probe_last = (pcnt_reg == LAST_IDX);
    assign probe_stop = slot_empty || slot_hit || probe_last;

    always_ff @(posedge aclk) begin
        if (cmd.probe_init) begin
            idx_reg       <= start_idx;
            pcnt_reg      <= '0;
            have_tomb_reg <= 1'b0;
        end else if (cmd.probe_step) begin
            idx_reg  <= idx_next;
            pcnt_reg <= pcnt_reg + 1'b1;
            if (slot_tomb && !have_tomb_reg) begin
                have_tomb_reg <= 1'b1;
                tomb_reg      <= idx_reg;
            end
        end
    end

    // Probe outcome
    always_ff @(posedge aclk) begin
        if (cmd.probe_step && probe_stop) begin
            hit_val_reg <= val_rd_reg;
            if (slot_hit) begin
                where_reg   <= idx_reg;
                matched_reg <= 1'b1;
                fresh_reg   <= 1'b0;
                ok_reg      <= 1'b1;
            end else if (slot_empty) begin
                where_reg   <= have_tomb_reg ? tomb_reg : idx_reg;
                matched_reg <= 1'b0;
                fresh_reg   <= !have_tomb_reg;
                ok_reg      <= 1'b1;
            end else begin
                // whole table walked without an empty slot
                where_reg   <= have_tomb_reg ? tomb_reg : idx_reg;
                matched_reg <= 1'b0;
                fresh_reg   <= 1'b0;
                ok_reg      <= have_tomb_reg || slot_tomb;
            end
        end
    end

    // Occupancy and commit decision
    logic [COUNT_W-1:0] count_reg, count_next;
    status_t            status_c;
    logic [VALUE_W-1:0] read_c;
    logic               over_limit;
    logic               key_zero;

    assign key_zero   = (key_reg == '0);
    assign over_limit = ({1'b0, count_reg} + 1'b1) > (COUNT_W+1)'(limit_reg);

    always_comb begin
        status_c         = STAT_MISSING;
        read_c           = '0;
        count_next       = count_reg;
        commit_key_we    = 1'b0;
        commit_key_wdata = {1'b0, key_reg};
        val_we           = 1'b0;
        unique case (op_reg)
            OP_CLEAR: begin
                status_c   = STAT_DELETED;
                count_next = '0;
            end
            OP_SET: begin
                if (!key_zero) begin
                    if (!ok_reg) begin
                        status_c = STAT_FULL;
                    end else if (matched_reg) begin
                        status_c = STAT_UPDATED;
                        val_we   = cmd.commit;
                    end else if (fresh_reg && over_limit) begin
                        status_c = STAT_FULL;
                    end else begin
                        status_c      = STAT_INSERTED;
                        commit_key_we = 1'b1;
                        val_we        = cmd.commit;
                        if (fresh_reg) count_next = count_reg + 1'b1;
                    end
                end
            end
            OP_GET: begin
                if (!key_zero && (count_reg != '0) && ok_reg && matched_reg) begin
                    status_c = STAT_FOUND;
                    read_c   = hit_val_reg;
                end
            end
            OP_DEL: begin
                if (!key_zero && (count_reg != '0) && ok_reg && matched_reg) begin
                    status_c         = STAT_DELETED;
                    commit_key_we    = 1'b1;
                    commit_key_wdata = {1'b1, {KEY_W{1'b0}}};
                end
            end
            default: begin
                status_c = STAT_MISSING;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    // Result register
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] status_out_reg;
    logic [VALUE_W-1:0]  read_out_reg;
    logic [COUNT_W-1:0]  occ_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_out_reg <= status_c;
            read_out_reg   <= read_c;
            occ_out_reg    <= count_next;
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign out_status     = status_out_reg;
    assign out_read_value = read_out_reg;
    assign out_occupancy  = occ_out_reg;

    // Status to controller
    always_comb begin
        sts            = '0;
        sts.mod_done   = mod_done;
        sts.is_clear   = (op_reg == OP_CLEAR);
        sts.trivial    = key_zero || ((op_reg != OP_SET) && (count_reg == '0));
        sts.probe_stop = probe_stop;
        sts.sweep_last = (sweep_reg == LAST_IDX);
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    `OAHT_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, cmd.commit, !m_tvalid_reg || m_tready, "result overwritten before it was taken")
    `OAHT_ASSERT_IMPL(a_valid_after_commit, aclk, aresetn, $rose(m_tvalid_reg), $past(cmd.commit), "result raised without a commit")
    `OAHT_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg[COUNT_W-1] == 1'b0, "occupancy above the largest load limit")

endmodule

// ===== rtl/open_addressing_hash_table.sv =====
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Keyed store with linear probing and tombstones: set, get, delete, clear.
// ----------------------------------------------------------------------------
//
//  Port group   Dir  Fields (low bit up)
//  s_*          in   op[1:0] key[33:2] key_hash[65:34] value[129:66]
//  m_*          out  status[2:0] read_value[66:3] occupancy[75:67]
//  cfg_*        in   load_limit[7:0]
//
//  An operation runs from acceptance through hash reduction, probe start, the
//  probe (one slot per cycle through the key store read port) and commit;
//  the reduction takes 8 hash bits a cycle when SLOTS is not a power of two.
//  Zero key, or get/delete on an empty table, skips the probe; clear sweeps
//  every slot. After reset the key store is swept before s_tready rises.
//  An untaken result holds the next operation at its commit step only.
//
module open_addressing_hash_table
    import oaht_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,     // op, key, key_hash, value, zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,     // status, read_value, occupancy, zero pad
    input  logic                 cfg_wr_en,
    input  logic [LIMIT_W-1:0]   cfg_wr_data  // load_limit
);

    oaht_cmd_t           cmd;
    oaht_sts_t           sts;
    logic [STATUS_W-1:0] out_status;
    logic [VALUE_W-1:0]  out_read_value;
    logic [COUNT_W-1:0]  out_occupancy;

    oaht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    oaht_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_op          (s_tdata[1:0]),
        .in_key         (s_tdata[33:2]),
        .in_hash        (s_tdata[65:34]),
        .in_value       (s_tdata[129:66]),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .out_status     (out_status),
        .out_read_value (out_read_value),
        .out_occupancy  (out_occupancy)
    );

    // Pack the result transaction
    assign m_tdata = {4'b0000, out_occupancy, out_read_value, out_status};

endmodule

// ===== sim/open_addressing_hash_table_tb.sv =====
// ----------------------------------------------------------------------------
// open_addressing_hash_table_tb
// Self-checking bench for the linear probing hash table. A behavioral copy
// of the table predicts status, read value and occupancy of every accepted
// request transaction, and each response transaction is checked against the
// oldest prediction. Directed cases are followed by random phases at several
// load limits, with random idling on both stream interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module open_addressing_hash_table_tb
    import oaht_pkg::*;
();

    localparam int unsigned TABLE_SLOTS = 256;
    localparam int unsigned POOL_MAX    = 1024;

    typedef struct packed {
        status_t               status;
        logic [VALUE_W-1:0]    read_value;
        logic [COUNT_W-1:0]    occupancy;
    } table_resp_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en;
    logic [LIMIT_W-1:0]   cfg_wr_data;

    // Behavioral copy of the table
    bit [KEY_W-1:0]   tbl_key   [TABLE_SLOTS];
    bit [VALUE_W-1:0] tbl_value [TABLE_SLOTS];
    bit               tbl_tomb  [TABLE_SLOTS];
    int unsigned      tbl_count;
    bit [LIMIT_W-1:0] tbl_limit;

    table_resp_t expected_resp_q[$];

    // Keys used by the random phases, each with a home slot
    bit [KEY_W-1:0] pool_key  [POOL_MAX];
    int unsigned    pool_slot [POOL_MAX];

    int gap_pct;
    int stall_pct;
    int error_count;

    open_addressing_hash_table #(
        .SLOTS(TABLE_SLOTS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void clear_table_model();
        foreach (tbl_key[i]) begin
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
            tbl_tomb[i]  = 1'b0;
        end
        tbl_count = 0;
    endfunction

    function automatic table_resp_t predict_table_op(op_t op, bit [KEY_W-1:0] key,
                                                     bit [HASH_W-1:0] key_hash,
                                                     bit [VALUE_W-1:0] value);
        table_resp_t r;
        int unsigned idx;
        int unsigned where;
        int unsigned tomb;
        bit          have_tomb;
        bit          hit;
        bit          matched;
        bit          fresh;

        r.status     = STAT_MISSING;
        r.read_value = '0;
        where        = 0;
        tomb         = 0;
        have_tomb    = 1'b0;
        hit          = 1'b0;
        matched      = 1'b0;
        fresh        = 1'b0;

        if (op == OP_CLEAR) begin
            clear_table_model();
            r.status = STAT_DELETED;
        end else if (key != 0 && (op == OP_SET || tbl_count != 0)) begin
            // linear probe: stop on a matching live key or a truly empty slot
            idx = key_hash % TABLE_SLOTS;
            for (int n = 0; n < TABLE_SLOTS && !hit; n++) begin
                if (tbl_key[idx] == 0) begin
                    if (!tbl_tomb[idx]) begin
                        hit = 1'b1;
                        if (have_tomb) begin
                            where = tomb;
                        end else begin
                            where = idx;
                            fresh = 1'b1;
                        end
                    end else if (!have_tomb) begin
                        have_tomb = 1'b1;
                        tomb      = idx;
                    end
                end else if (tbl_key[idx] == key) begin
                    hit     = 1'b1;
                    matched = 1'b1;
                    where   = idx;
                end
                idx = (idx + 1) % TABLE_SLOTS;
            end
            if (!hit && have_tomb) begin
                hit   = 1'b1;
                where = tomb;
            end

            case (op)
                OP_SET: begin
                    if (!hit) begin
                        r.status = STAT_FULL;
                    end else if (matched) begin
                        tbl_value[where] = value;
                        r.status         = STAT_UPDATED;
                    end else if (fresh && tbl_count + 1 > tbl_limit) begin
                        r.status = STAT_FULL;
                    end else begin
                        if (fresh)
                            tbl_count++;
                        tbl_key[where]   = key;
                        tbl_value[where] = value;
                        tbl_tomb[where]  = 1'b0;
                        r.status         = STAT_INSERTED;
                    end
                end
                OP_GET: begin
                    if (matched) begin
                        r.read_value = tbl_value[where];
                        r.status     = STAT_FOUND;
                    end
                end
                default: begin
                    if (matched) begin
                        tbl_key[where]  = '0;
                        tbl_tomb[where] = 1'b1;
                        r.status        = STAT_DELETED;
                    end
                end
            endcase
        end
        r.occupancy = tbl_count[COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Response check, one transaction per accepting edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        table_resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_resp_q.size() == 0) begin
                $error("response transaction with no request outstanding");
                error_count++;
            end else begin
                want = expected_resp_q.pop_front();
                if (m_tdata[2:0] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
                    error_count++;
                end
                if (m_tdata[66:3] !== want.read_value) begin
                    $error("read_value: expected %h, actual %h",
                           want.read_value, m_tdata[66:3]);
                    error_count++;
                end
                if (m_tdata[75:67] !== want.occupancy) begin
                    $error("occupancy: expected %0d, actual %0d",
                           want.occupancy, m_tdata[75:67]);
                    error_count++;
                end
            end
        end
    end

    // Receiver backpressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------
    // One request transaction; valid stays high after acceptance until the
    // next falling edge, where the next call either replaces or drops it.
    task automatic send_table_op(op_t op, bit [KEY_W-1:0] key,
                                 bit [HASH_W-1:0] key_hash, bit [VALUE_W-1:0] value);
        @(negedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {{(S_TDATA_W-130){1'b0}}, value, key_hash, key, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_resp_q.push_back(predict_table_op(op, key, key_hash, value));
    endtask

    // Hold off the sender until every prediction has been answered
    task automatic wait_table_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_resp_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_load_limit(bit [LIMIT_W-1:0] limit);
        wait_table_idle();
        @(negedge aclk);
        cfg_wr_data <= limit;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tbl_limit = limit;
    endtask

    // Keys with home slots drawn from a window that may wrap past the top
    task automatic build_key_pool(int unsigned count, int unsigned base, int unsigned span);
        for (int i = 0; i < count; i++) begin
            pool_key[i] = $urandom;
            if (pool_key[i] == 0)
                pool_key[i] = 1;
            pool_slot[i] = (base + $urandom_range(span - 1)) % TABLE_SLOTS;
        end
    endtask

    task automatic send_random_op(int unsigned pool_n, int set_pct, int clear_pct);
        int             roll;
        int unsigned    pick;
        op_t            op;
        bit [KEY_W-1:0]  key;
        bit [HASH_W-1:0] key_hash;

        roll = $urandom_range(99);
        if (roll < clear_pct)
            op = OP_CLEAR;
        else if (roll < clear_pct + set_pct)
            op = OP_SET;
        else if ($urandom_range(4) < 3)
            op = OP_GET;
        else
            op = OP_DEL;

        // consistent key/hash pairs, random upper hash bits
        pick     = $urandom_range(pool_n - 1);
        key      = pool_key[pick];
        key_hash = ($urandom / TABLE_SLOTS) * TABLE_SLOTS + pool_slot[pick];

        // a little noise: zero key, stray hash, unknown key
        roll = $urandom_range(99);
        if (roll < 3)
            key = '0;
        else if (roll < 6)
            key_hash = $urandom;
        else if (roll < 8)
            key = $urandom | 32'h1;

        send_table_op(op, key, key_hash, {$urandom, $urandom});
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_ops();
        gap_pct   = 22;
        stall_pct = 47;
        // empty table answers without probing
        send_table_op(OP_GET, 32'h1234_5678, 32'h0, 64'h0);
        send_table_op(OP_DEL, 32'h1234_5678, 32'h0, 64'h0);
        // insert, update, read back
        send_table_op(OP_SET, 32'h1234_5678, 32'h0, '1);
        send_table_op(OP_SET, 32'h1234_5678, 32'h0, 64'h0);
        send_table_op(OP_GET, 32'h1234_5678, 32'h0, '1);
        // top slot, a collision and a wrap past the top slot
        send_table_op(OP_SET, 32'h8000_0000, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001);
        send_table_op(OP_SET, 32'h0BAD_F00D, 32'h0000_0100, 64'h0123_4567_89AB_CDEF);
        send_table_op(OP_SET, 32'hFFFF_FFFF, 32'h0000_00FF, 64'hFEDC_BA98_7654_3210);
        send_table_op(OP_GET, 32'hFFFF_FFFF, 32'h0000_00FF, 64'h0);
        // zero key is never stored
        send_table_op(OP_GET, 32'h0, 32'h0, 64'h0);
        send_table_op(OP_DEL, 32'h0, 32'h0, 64'h0);
        send_table_op(OP_SET, 32'h0, 32'h0, '1);
        // delete leaves a tombstone that probes walk past and inserts reuse
        send_table_op(OP_DEL, 32'h1234_5678, 32'h0, 64'h0);
        send_table_op(OP_GET, 32'h0BAD_F00D, 32'h0000_0100, 64'h0);
        send_table_op(OP_GET, 32'h1234_5678, 32'h0, 64'h0);
        send_table_op(OP_SET, 32'h0000_0002, 32'h8000_0000, 64'h5A5A_5A5A_A5A5_A5A5);
        send_table_op(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, 64'h0);
        send_table_op(OP_CLEAR, 32'h0, 32'h0, 64'h0);
        send_table_op(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, 64'h0);

        // load limit of one: one fresh slot, tombstone reuse still allowed
        write_load_limit(8'd1);
        send_table_op(OP_SET, 32'h5555_5555, 32'hAAAA_AAAA, 64'h1111_2222_3333_4444);
        send_table_op(OP_SET, 32'hAAAA_AAAA, 32'h5555_5555, 64'h0);
        send_table_op(OP_SET, 32'h5555_5555, 32'hAAAA_AAAA, 64'h4444_3333_2222_1111);
        send_table_op(OP_DEL, 32'h5555_5555, 32'hAAAA_AAAA, 64'h0);
        send_table_op(OP_SET, 32'hAAAA_AAAA, 32'h0000_00AA, 64'hDEAD_BEEF_CAFE_F00D);
        send_table_op(OP_SET, 32'h1234_5678, 32'h0, 64'h0);
        send_table_op(OP_CLEAR, 32'h0, 32'h0, 64'h0);
    endtask

    // Largest limit, wide key set: fills the table until inserts are refused
    task automatic test_fill_to_limit();
        write_load_limit(8'd255);
        gap_pct   = 22;
        stall_pct = 47;
        build_key_pool(POOL_MAX, 0, TABLE_SLOTS);
        repeat (450) send_random_op(POOL_MAX, 75, 0);
    endtask

    // Tight limit, few keys crowded round the wrap point, frequent clears
    task automatic test_small_limit_churn();
        write_load_limit(8'd12);
        gap_pct   = 47;
        stall_pct = 22;
        build_key_pool(24, 248, 16);
        repeat (300) send_random_op(24, 50, 3);
    endtask

    // Reset limit value, medium key set with heavy clustering
    task automatic test_default_limit_mix();
        write_load_limit(LOAD_LIMIT_RESET);
        gap_pct   = 0;
        stall_pct = 0;
        build_key_pool(64, 100, 40);
        repeat (250) send_random_op(64, 55, 2);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        gap_pct     = 22;
        stall_pct   = 47;
        error_count = 0;
        clear_table_model();
        tbl_limit   = LOAD_LIMIT_RESET;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_ops();
        test_fill_to_limit();
        test_small_limit_churn();
        test_default_limit_mix();
        wait_table_idle();

        if (error_count == 0 && expected_resp_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
